// ===== design/evs_pkg.sv =====
// shared constants, register codes and types for the energy vad segmenter
`default_nettype none

package evs_pkg;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_INDEX_BITS  = 32;
  localparam int MAX_FRAME       = 4096;

  localparam int FS_W     = 13;
  localparam int ENERGY_W = 43;
  localparam int LEN_W    = 20;
  localparam int CNT_W    = 21;
  localparam int OVL_W    = 19;
  localparam int START_W  = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = ENERGY_W;

  localparam int OUT_LEN_LSB = START_W;
  localparam int OUT_OVL_LSB = START_W + CNT_W;
  localparam int OUT_DATA_W  = START_W + CNT_W + OVL_W;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_SAMPLES = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEECH    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HANGOVER      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SEGMENT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OVERLAP       = 3'd5;

  localparam logic [FS_W-1:0]     RST_FRAME_SAMPLES = 13'd480;
  localparam logic [ENERGY_W-1:0] RST_THRESHOLD     = 43'd4800000;
  localparam logic [LEN_W-1:0]    RST_MIN_SPEECH    = 20'd4000;
  localparam logic [LEN_W-1:0]    RST_HANGOVER      = 20'd8000;
  localparam logic [LEN_W-1:0]    RST_MAX_SEGMENT   = 20'd480000;
  localparam logic [LEN_W-1:0]    RST_OVERLAP       = 20'd0;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic [FS_W-1:0]     frame_samples;
    logic [ENERGY_W-1:0] threshold;
    logic [LEN_W-1:0]    min_speech;
    logic [LEN_W-1:0]    hangover;
    logic [LEN_W-1:0]    max_segment;
    logic [LEN_W-1:0]    overlap;
  } cfg_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [CNT_W-1:0]   length;
    logic               cont;
    logic [OVL_W-1:0]   overlap;
  } seg_t;

endpackage

`default_nettype wire

// ===== design/evs_frontend.sv =====
// input register and squaring stage
`default_nettype none

module evs_frontend #(
  parameter int SAMPLE_BITS = evs_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_take,
  output logic                               out_cmd,
  output logic [2*SAMPLE_BITS-1:0]           out_sq
);
  import evs_pkg::*;

  logic                          s1_valid;
  logic                          s1_cmd;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [2*SAMPLE_BITS-1:0] product;
  logic                          s2_free;

  assign s2_free  = !out_valid || out_take;
  assign in_ready = !s1_valid || s2_free;
  assign product  = s1_sample * s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s2_free) out_valid <= s1_valid;
    end
    if (in_valid && in_ready) begin
      s1_cmd    <= in_cmd;
      s1_sample <= in_sample;
    end
    if (s1_valid && s2_free) begin
      out_cmd <= s1_cmd;
      out_sq  <= unsigned'(product);
    end
  end

endmodule

`default_nettype wire

// ===== design/evs_tracker.sv =====
// frame energy accumulation and segment tracking state
`default_nettype none

module evs_tracker #(
  parameter int SAMPLE_BITS = evs_pkg::DEF_SAMPLE_BITS,
  parameter int INDEX_BITS  = evs_pkg::DEF_INDEX_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   cmd,
  input  wire logic [2*SAMPLE_BITS-1:0] sq,
  input  wire evs_pkg::cfg_t          cfg,
  output logic                        res_valid,
  output evs_pkg::seg_t               res
);
  import evs_pkg::*;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;
  localparam logic [SUM_W-1:0] ENERGY_MAX = SUM_W'({ENERGY_W{1'b1}});

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  logic [INDEX_BITS-1:0] sample_index, sample_index_next;
  logic [FS_W-1:0]       frame_fill, frame_fill_next;
  logic [ENERGY_W-1:0]   energy_acc, energy_acc_next;
  logic                  in_speech, in_speech_next;
  logic [INDEX_BITS-1:0] segment_start, segment_start_next;
  logic [CNT_W-1:0]      segment_length, segment_length_next;
  logic [CNT_W-1:0]      speech_count, speech_count_next;
  logic [CNT_W-1:0]      trailing_silence, trailing_silence_next;
  logic                  pending_continue, pending_continue_next;
  logic [OVL_W-1:0]      pending_overlap, pending_overlap_next;

  logic [FS_W-1:0]  frame_eff;
  logic [LEN_W-1:0] max_eff;
  logic [OVL_W-1:0] half_max;

  logic [SUM_W-1:0]      sum;
  logic [ENERGY_W-1:0]   acc_sat;
  logic [FS_W-1:0]       fill_inc;
  logic [INDEX_BITS-1:0] idx_inc;
  logic                  frame_done;
  logic                  is_speech;
  logic                  speech1;
  logic [INDEX_BITS-1:0] start1;
  logic [CNT_W-1:0]      len_base, len1, sc1, ts1;
  logic                  do_close, force_cap, qualifies;
  logic [CNT_W-1:0]      carry_lim;
  logic [OVL_W-1:0]      carry;

  // zero is used as one, oversize as the largest frame
  always_comb begin
    if (cfg.frame_samples == '0) frame_eff = FS_W'(1);
    else if (32'(cfg.frame_samples) > 32'(MAX_FRAME)) frame_eff = FS_W'(MAX_FRAME);
    else frame_eff = cfg.frame_samples;
  end

  assign max_eff  = (cfg.max_segment < LEN_W'(frame_eff)) ? LEN_W'(frame_eff)
                                                          : cfg.max_segment;
  assign half_max = max_eff[LEN_W-1:1];

  assign sum        = SUM_W'(energy_acc) + SUM_W'(sq);
  assign acc_sat    = (sum > ENERGY_MAX) ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
  assign fill_inc   = frame_fill + 1'b1;
  assign idx_inc    = sample_index + 1'b1;
  assign frame_done = fill_inc >= frame_eff;
  assign is_speech  = acc_sat >= cfg.threshold;

  always_comb begin
    speech1   = in_speech;
    start1    = segment_start;
    len_base  = segment_length;
    len1      = segment_length;
    sc1       = speech_count;
    ts1       = trailing_silence;
    do_close  = 1'b0;
    force_cap = 1'b0;

    sample_index_next = sample_index;
    frame_fill_next   = '0;
    energy_acc_next   = '0;

    if (cmd == CMD_FLUSH) begin
      // partial frame folds into an open segment, then it closes
      if (in_speech) begin
        len1     = sat_cnt(segment_length, CNT_W'(frame_fill));
        do_close = 1'b1;
      end
    end else begin
      sample_index_next = idx_inc;
      if (!frame_done) begin
        frame_fill_next = fill_inc;
        energy_acc_next = acc_sat;
      end else begin
        if (is_speech) begin
          speech1 = 1'b1;
          if (!in_speech) begin
            len_base = '0;
            start1   = idx_inc - INDEX_BITS'(fill_inc);
          end
          ts1  = '0;
          len1 = sat_cnt(len_base, CNT_W'(fill_inc));
          sc1  = sat_cnt(speech_count, CNT_W'(fill_inc));
        end else if (in_speech) begin
          len1 = sat_cnt(segment_length, CNT_W'(fill_inc));
          ts1  = sat_cnt(trailing_silence, CNT_W'(fill_inc));
          if (ts1 >= CNT_W'(cfg.hangover)) do_close = 1'b1;
        end
        if (speech1 && !do_close && len1 >= CNT_W'(max_eff)) begin
          do_close  = 1'b1;
          force_cap = 1'b1;
        end
      end
    end
  end

  assign qualifies = sc1 >= CNT_W'(cfg.min_speech);

  // tail carried over a cap close: min(overlap, length, max/2)
  always_comb begin
    carry_lim = CNT_W'(cfg.overlap);
    if (len1 < carry_lim) carry_lim = len1;
    if (CNT_W'(half_max) < carry_lim) carry_lim = CNT_W'(half_max);
    if (force_cap && cfg.overlap != '0 && qualifies && ts1 == '0) begin
      carry = carry_lim[OVL_W-1:0];
    end else begin
      carry = '0;
    end
  end

  always_comb begin
    in_speech_next        = speech1;
    segment_start_next    = start1;
    segment_length_next   = len1;
    speech_count_next     = sc1;
    trailing_silence_next = ts1;
    pending_continue_next = pending_continue;
    pending_overlap_next  = pending_overlap;
    res_valid             = 1'b0;
    res.start             = START_W'(start1);
    res.length            = len1;
    res.cont              = pending_continue;
    res.overlap           = pending_continue ? pending_overlap : '0;

    if (do_close) begin
      res_valid             = qualifies;
      trailing_silence_next = '0;
      speech_count_next     = '0;
      pending_continue_next = 1'b0;
      pending_overlap_next  = '0;
      if (carry != '0) begin
        segment_start_next    = start1 + INDEX_BITS'(len1) - INDEX_BITS'(carry);
        segment_length_next   = CNT_W'(carry);
        speech_count_next     = CNT_W'(carry);
        pending_continue_next = 1'b1;
        pending_overlap_next  = carry;
      end else begin
        in_speech_next      = 1'b0;
        segment_length_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      frame_fill       <= '0;
      energy_acc       <= '0;
      in_speech        <= 1'b0;
      segment_start    <= '0;
      segment_length   <= '0;
      speech_count     <= '0;
      trailing_silence <= '0;
      pending_continue <= 1'b0;
      pending_overlap  <= '0;
    end else if (step) begin
      sample_index     <= sample_index_next;
      frame_fill       <= frame_fill_next;
      energy_acc       <= energy_acc_next;
      in_speech        <= in_speech_next;
      segment_start    <= segment_start_next;
      segment_length   <= segment_length_next;
      speech_count     <= speech_count_next;
      trailing_silence <= trailing_silence_next;
      pending_continue <= pending_continue_next;
      pending_overlap  <= pending_overlap_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/energy_vad_segmenter_core.sv =====
// energy vad segmenter top level: config registers, pipeline and result register
// closing transactions pass the input and square registers; descriptors are then registered
// throughput: one transaction per cycle unless a closing result waits on m_tready
// stages: input register, square register, segment state with result register
// reset: synchronous rst empties the pipeline, clears all segment state and
// returns the config registers to their default values
`default_nettype none

module energy_vad_segmenter_core #(
  parameter int SAMPLE_BITS = evs_pkg::DEF_SAMPLE_BITS,
  parameter int INDEX_BITS  = evs_pkg::DEF_INDEX_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  // cmd
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // seg_start, seg_length, carried_overlap
  output logic [evs_pkg::OUT_DATA_W-1:0]          m_tdata,
  // continues_previous
  output logic                                    m_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [evs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [evs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import evs_pkg::*;

  cfg_t                     cfg;
  logic                     fe_valid;
  logic                     fe_cmd;
  logic [2*SAMPLE_BITS-1:0] fe_sq;
  logic                     step;
  logic                     res_valid;
  seg_t                     res;
  seg_t                     out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_samples <= RST_FRAME_SAMPLES;
      cfg.threshold     <= RST_THRESHOLD;
      cfg.min_speech    <= RST_MIN_SPEECH;
      cfg.hangover      <= RST_HANGOVER;
      cfg.max_segment   <= RST_MAX_SEGMENT;
      cfg.overlap       <= RST_OVERLAP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_SAMPLES: cfg.frame_samples <= cfg_wdata[FS_W-1:0];
        REG_THRESHOLD:     cfg.threshold     <= cfg_wdata[ENERGY_W-1:0];
        REG_MIN_SPEECH:    cfg.min_speech    <= cfg_wdata[LEN_W-1:0];
        REG_HANGOVER:      cfg.hangover      <= cfg_wdata[LEN_W-1:0];
        REG_MAX_SEGMENT:   cfg.max_segment   <= cfg_wdata[LEN_W-1:0];
        REG_OVERLAP:       cfg.overlap       <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  evs_frontend #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_frontend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_sample(signed'(s_tdata[SAMPLE_BITS-1:0])),
    .out_valid(fe_valid),
    .out_take (step),
    .out_cmd  (fe_cmd),
    .out_sq   (fe_sq)
  );

  // a transaction that closes nothing never waits on the result register
  assign step = fe_valid && (!res_valid || !m_tvalid || m_tready);

  evs_tracker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (fe_cmd),
    .sq       (fe_sq),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (step && res_valid) out_res <= res;
  end

  assign m_tdata = {out_res.overlap, out_res.length, out_res.start};
  assign m_tuser = out_res.cont;

endmodule

`default_nettype wire

// ===== design/evs_checker.sv =====
// port-level checks for the energy vad segmenter, bound to the top level
`default_nettype none

module evs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [evs_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                          m_tuser
);
  import evs_pkg::*;

  logic [CNT_W-1:0] seg_len;
  logic [OVL_W-1:0] seg_ovl;

  assign seg_len = m_tdata[OUT_OVL_LSB-1:OUT_LEN_LSB];
  assign seg_ovl = m_tdata[OUT_DATA_W-1:OUT_OVL_LSB];

  a_reset_state: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // every closed segment holds at least one frame sample
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> seg_len != '0)
    else $error("empty segment emitted");

  // carried tail is only reported with the continuation flag and fits the segment
  a_carry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser ? (seg_ovl != '0 && seg_len >= CNT_W'(seg_ovl))
                          : (seg_ovl == '0)))
    else $error("carried overlap inconsistent with continuation flag");

endmodule

bind energy_vad_segmenter_core evs_checker u_evs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
